// ===== hdl/ray_hit_light_cosine_assert.svh =====
// Assertion macros for the ray hit shading pipeline.
`ifndef RAY_HIT_LIGHT_COSINE_ASSERT_SVH
`define RAY_HIT_LIGHT_COSINE_ASSERT_SVH
`ifndef SYNTHESIS
`define RHLC_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhlc assertion failed");
`define RHLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhlc assertion failed");
`else
`define RHLC_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define RHLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rhlc_pkg.sv =====
package rhlc_pkg;

    localparam int XW        = 32;
    localparam int DIST_W    = 31;
    localparam int SAT_W     = 2 * XW + 2;
    localparam int NORM_TOP  = 22;
    localparam int VEC_W     = NORM_TOP + 2;
    localparam int POS_W     = 5;
    localparam int PROD_W    = 2 * VEC_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int SQ_W      = PROD_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int DEN_W     = 2 * ROOT_W;
    localparam int COS_W     = 16;
    localparam int COS_FRAC  = 14;
    localparam int COLOUR_W  = 24;
    localparam int TYPE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam int SQRT_BPS    = 3;
    localparam int SQRT_STAGES = ROOT_W / SQRT_BPS;
    localparam int DIV_BPS     = 2;
    localparam int DIV_STAGES  = COS_FRAC / DIV_BPS;

    localparam logic signed [COS_W-1:0] COS_ONE = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z = 2'd2;

    localparam logic [TYPE_W-1:0] KIND_SPHERE   = 2'd0;
    localparam logic [TYPE_W-1:0] KIND_CYLINDER = 2'd1;
    localparam logic [TYPE_W-1:0] KIND_CONE     = 2'd2;

    localparam logic [COLOUR_W-1:0] COLOUR_SPHERE = 24'hFF0000;
    localparam logic [COLOUR_W-1:0] COLOUR_ROUND  = 24'h0000FF;

    typedef logic signed [XW-1:0]    coord_t;
    typedef logic signed [VEC_W-1:0] nvec_t;

    typedef struct packed {
        logic                    degen;
        logic                    round_kind;
        logic signed [DOT_W-1:0] dot;
    } side_t;

    function automatic coord_t sat32(input logic signed [SAT_W-1:0] v);
        if ((&v[SAT_W-1:XW-1]) || !(|v[SAT_W-1:XW-1]))
            return v[XW-1:0];
        else if (v[SAT_W-1])
            return {1'b1, {(XW-1){1'b0}}};
        else
            return {1'b0, {(XW-1){1'b1}}};
    endfunction

endpackage

// ===== hdl/rhlc_point.sv =====
module rhlc_point #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           vld,
    input  logic                           round_kind,
    input  rhlc_pkg::coord_t [2:0]         origin,
    input  rhlc_pkg::coord_t [2:0]         dir,
    input  rhlc_pkg::coord_t [2:0]         light,
    input  logic [rhlc_pkg::DIST_W-1:0]    hit_dist,
    output logic                           vld_out,
    output logic                           round_out,
    output rhlc_pkg::coord_t [2:0]         n,
    output rhlc_pkg::coord_t [2:0]         l
);

    localparam int PW = 2 * rhlc_pkg::XW;

    logic                              vld_a_reg, vld_b_reg, vld_c_reg;
    logic                              round_a_reg, round_b_reg, round_c_reg;
    logic signed [PW-1:0]              prod_reg [3];
    rhlc_pkg::coord_t                  orig_a_reg [3];
    rhlc_pkg::coord_t                  p_reg [3];
    rhlc_pkg::coord_t                  n_reg [3];
    rhlc_pkg::coord_t                  l_reg [3];
    logic signed [rhlc_pkg::SAT_W-1:0] sum_next [3];
    logic signed [rhlc_pkg::SAT_W-1:0] diff_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i]  = rhlc_pkg::SAT_W'(orig_a_reg[i])
                         + rhlc_pkg::SAT_W'(prod_reg[i] >>> FRAC_BITS);
            diff_next[i] = rhlc_pkg::SAT_W'($signed(light[i]))
                         - rhlc_pkg::SAT_W'(p_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg <= vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            round_a_reg <= round_kind;
            round_b_reg <= round_a_reg;
            round_c_reg <= round_b_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i]   <= PW'($signed(dir[i])) * PW'($signed({1'b0, hit_dist}));
                orig_a_reg[i] <= $signed(origin[i]);
                p_reg[i]      <= rhlc_pkg::sat32(sum_next[i]);
                l_reg[i]      <= rhlc_pkg::sat32(diff_next[i]);
            end
            n_reg[0] <= p_reg[0];
            n_reg[1] <= p_reg[1];
            n_reg[2] <= round_b_reg ? '0 : p_reg[2];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n[i] = n_reg[i];
            l[i] = l_reg[i];
        end
    end

    assign vld_out   = vld_c_reg;
    assign round_out = round_c_reg;

endmodule

// ===== hdl/rhlc_norm.sv =====
module rhlc_norm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   vld,
    input  logic                   round_kind,
    input  rhlc_pkg::coord_t [2:0] n,
    input  rhlc_pkg::coord_t [2:0] l,
    output logic                   vld_out,
    output logic                   degen,
    output logic                   round_out,
    output rhlc_pkg::nvec_t [2:0]  nv,
    output rhlc_pkg::nvec_t [2:0]  lv
);

    localparam int XW = rhlc_pkg::XW;
    localparam int PW = rhlc_pkg::POS_W;

    logic                vld_a_reg, vld_b_reg;
    logic                round_a_reg, round_b_reg;
    logic                degen_a_reg, degen_b_reg;
    rhlc_pkg::coord_t    n_a_reg [3];
    rhlc_pkg::coord_t    l_a_reg [3];
    logic [PW-1:0]       pos_n_reg, pos_l_reg;
    rhlc_pkg::nvec_t     nv_reg [3];
    rhlc_pkg::nvec_t     lv_reg [3];
    logic [XW-1:0]       or_n, or_l;
    logic                zero_n, zero_l;

    function automatic logic [XW-1:0] magn(input rhlc_pkg::coord_t v);
        return v[XW-1] ? XW'(-v) : XW'(v);
    endfunction

    function automatic logic [PW-1:0] top_bit(input logic [XW-1:0] m);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (m[i])
                p = PW'(i);
        end
        return p;
    endfunction

    // common shift so the largest magnitude tops out at NORM_TOP
    function automatic rhlc_pkg::nvec_t scale(input rhlc_pkg::coord_t v,
                                              input logic [PW-1:0] p);
        logic [XW-1:0] m;
        logic [XW-1:0] a;
        m = magn(v);
        if (p > PW'(rhlc_pkg::NORM_TOP))
            a = m >> (p - PW'(rhlc_pkg::NORM_TOP));
        else
            a = m << (PW'(rhlc_pkg::NORM_TOP) - p);
        return v[XW-1] ? -a[rhlc_pkg::VEC_W-1:0] : a[rhlc_pkg::VEC_W-1:0];
    endfunction

    always_comb
    begin
        or_n   = magn(n[0]) | magn(n[1]) | magn(n[2]);
        or_l   = magn(l[0]) | magn(l[1]) | magn(l[2]);
        zero_n = !(|or_n);
        zero_l = !(|or_l);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg <= vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            round_a_reg <= round_kind;
            round_b_reg <= round_a_reg;
            degen_a_reg <= zero_n || zero_l;
            degen_b_reg <= degen_a_reg;
            pos_n_reg   <= top_bit(or_n);
            pos_l_reg   <= top_bit(or_l);
            for (int i = 0; i < 3; i++)
            begin
                n_a_reg[i] <= $signed(n[i]);
                l_a_reg[i] <= $signed(l[i]);
                nv_reg[i]  <= scale(n_a_reg[i], pos_n_reg);
                lv_reg[i]  <= scale(l_a_reg[i], pos_l_reg);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = nv_reg[i];
            lv[i] = lv_reg[i];
        end
    end

    assign vld_out   = vld_b_reg;
    assign degen     = degen_b_reg;
    assign round_out = round_b_reg;

endmodule

// ===== hdl/rhlc_dot.sv =====
module rhlc_dot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vld,
    input  logic                          degen,
    input  logic                          round_kind,
    input  rhlc_pkg::nvec_t [2:0]         nv,
    input  rhlc_pkg::nvec_t [2:0]         lv,
    output logic                          vld_out,
    output rhlc_pkg::side_t               side,
    output logic [rhlc_pkg::SQ_W-1:0]     nn,
    output logic [rhlc_pkg::SQ_W-1:0]     ll
);

    localparam int PW = rhlc_pkg::PROD_W;
    localparam int DW = rhlc_pkg::DOT_W;
    localparam int SW = rhlc_pkg::SQ_W;

    logic                 vld_a_reg, vld_b_reg;
    logic                 degen_a_reg, degen_b_reg;
    logic                 round_a_reg, round_b_reg;
    logic signed [PW-1:0] pd_reg [3];
    logic signed [PW-1:0] pn_reg [3];
    logic signed [PW-1:0] pl_reg [3];
    logic signed [DW-1:0] dot_reg;
    logic [SW-1:0]        nn_reg, ll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg <= vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            degen_a_reg <= degen;
            degen_b_reg <= degen_a_reg;
            round_a_reg <= round_kind;
            round_b_reg <= round_a_reg;
            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= PW'($signed(nv[i])) * PW'($signed(lv[i]));
                pn_reg[i] <= PW'($signed(nv[i])) * PW'($signed(nv[i]));
                pl_reg[i] <= PW'($signed(lv[i])) * PW'($signed(lv[i]));
            end
            dot_reg <= DW'(pd_reg[0]) + DW'(pd_reg[1]) + DW'(pd_reg[2]);
            nn_reg  <= SW'(pn_reg[0] + pn_reg[1] + pn_reg[2]);
            ll_reg  <= SW'(pl_reg[0] + pl_reg[1] + pl_reg[2]);
        end
    end

    assign vld_out         = vld_b_reg;
    assign side.degen      = degen_b_reg;
    assign side.round_kind = round_b_reg;
    assign side.dot        = dot_reg;
    assign nn              = nn_reg;
    assign ll              = ll_reg;

endmodule

// ===== hdl/rhlc_sqrt.sv =====
`include "ray_hit_light_cosine_assert.svh"

module rhlc_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vld,
    input  rhlc_pkg::side_t               side,
    input  logic [rhlc_pkg::SQ_W-1:0]     rad_n,
    input  logic [rhlc_pkg::SQ_W-1:0]     rad_l,
    output logic                          vld_out,
    output rhlc_pkg::side_t               side_out,
    output logic [rhlc_pkg::ROOT_W-1:0]   root_n,
    output logic [rhlc_pkg::ROOT_W-1:0]   root_l
);

    localparam int SW    = rhlc_pkg::SQ_W;
    localparam int RW    = rhlc_pkg::ROOT_W;
    localparam int REM_W = RW + 3;
    localparam int NS    = rhlc_pkg::SQRT_STAGES;

    logic            vld_reg  [NS];
    rhlc_pkg::side_t side_reg [NS];
    logic [SW-1:0]    rad_reg  [NS][2];
    logic [REM_W-1:0] rem_reg  [NS][2];
    logic [RW-1:0]    root_reg [NS][2];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic             cur_vld;
        rhlc_pkg::side_t  cur_side;
        logic [SW-1:0]    cur_rad  [2];
        logic [REM_W-1:0] cur_rem  [2];
        logic [RW-1:0]    cur_root [2];
        logic [SW-1:0]    rad_next  [2];
        logic [REM_W-1:0] rem_next  [2];
        logic [RW-1:0]    root_next [2];

        if (s == 0)
        begin : g_in
            assign cur_vld     = vld;
            assign cur_side    = side;
            assign cur_rad[0]  = rad_n;
            assign cur_rad[1]  = rad_l;
            assign cur_rem[0]  = '0;
            assign cur_rem[1]  = '0;
            assign cur_root[0] = '0;
            assign cur_root[1] = '0;
        end
        else
        begin : g_mid
            assign cur_vld     = vld_reg[s-1];
            assign cur_side    = side_reg[s-1];
            assign cur_rad[0]  = rad_reg[s-1][0];
            assign cur_rad[1]  = rad_reg[s-1][1];
            assign cur_rem[0]  = rem_reg[s-1][0];
            assign cur_rem[1]  = rem_reg[s-1][1];
            assign cur_root[0] = root_reg[s-1][0];
            assign cur_root[1] = root_reg[s-1][1];
        end

        // one root bit per step, two radicand bits consumed
        always_comb
        begin
            for (int j = 0; j < 2; j++)
            begin
                rad_next[j]  = cur_rad[j];
                rem_next[j]  = cur_rem[j];
                root_next[j] = cur_root[j];
                for (int k = 0; k < rhlc_pkg::SQRT_BPS; k++)
                begin
                    rem_next[j] = {rem_next[j][REM_W-3:0], rad_next[j][SW-1 -: 2]};
                    rad_next[j] = rad_next[j] << 2;
                    if (rem_next[j] >= REM_W'({root_next[j], 2'b01}))
                    begin
                        rem_next[j]  = rem_next[j] - REM_W'({root_next[j], 2'b01});
                        root_next[j] = {root_next[j][RW-2:0], 1'b1};
                    end
                    else
                    begin
                        root_next[j] = {root_next[j][RW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= cur_vld;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[s] <= cur_side;
                for (int j = 0; j < 2; j++)
                begin
                    rad_reg[s][j]  <= rad_next[j];
                    rem_reg[s][j]  <= rem_next[j];
                    root_reg[s][j] <= root_next[j];
                end
            end
        end
    end

    assign vld_out  = vld_reg[NS-1];
    assign side_out = side_reg[NS-1];
    assign root_n   = root_reg[NS-1][0];
    assign root_l   = root_reg[NS-1][1];

    `RHLC_ASSERT_NEXT(a_sqrt_valid_travels, clk, rst_n, adv && vld_reg[0], vld_reg[1])
    `RHLC_ASSERT_HOLDS(a_root_n_scaled, clk, rst_n, vld_out && !side_out.degen, root_n[RW-1:RW-2] != 2'b00)
    `RHLC_ASSERT_HOLDS(a_root_l_scaled, clk, rst_n, vld_out && !side_out.degen, root_l[RW-1:RW-2] != 2'b00)

endmodule

// ===== hdl/rhlc_div.sv =====
module rhlc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                vld,
    input  rhlc_pkg::side_t                     side,
    input  logic [rhlc_pkg::ROOT_W-1:0]         root_n,
    input  logic [rhlc_pkg::ROOT_W-1:0]         root_l,
    output logic                                vld_out,
    output logic signed [rhlc_pkg::COS_W-1:0]   cosine,
    output logic [rhlc_pkg::COLOUR_W-1:0]       colour,
    output logic                                degenerate
);

    localparam int DW = rhlc_pkg::DEN_W;
    localparam int QW = rhlc_pkg::COS_FRAC;
    localparam int CW = rhlc_pkg::COS_W;
    localparam int NS = rhlc_pkg::DIV_STAGES;

    typedef struct packed {
        logic degen;
        logic round_kind;
        logic neg;
        logic big;
    } dflag_t;

    logic signed [rhlc_pkg::DOT_W-1:0] dot_abs;

    logic          vld0_reg, vld1_reg;
    dflag_t        fl0_reg, fl1_reg;
    logic [DW-1:0] den0_reg, den1_reg;
    logic [DW:0]   abs0_reg, rem1_reg;

    logic          vld_reg [NS];
    dflag_t        fl_reg  [NS];
    logic [DW-1:0] den_reg [NS];
    logic [DW:0]   rem_reg [NS];
    logic [QW-1:0] q_reg   [NS];

    logic                 vld_out_reg;
    logic signed [CW-1:0] cos_reg;
    logic [rhlc_pkg::COLOUR_W-1:0] colour_reg;
    logic                 degen_reg;
    logic signed [CW-1:0] mag_next;

    assign dot_abs = side.dot[rhlc_pkg::DOT_W-1] ? -side.dot : side.dot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg    <= 1'b0;
            vld1_reg    <= 1'b0;
            vld_out_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld0_reg    <= vld;
            vld1_reg    <= vld0_reg;
            vld_out_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den0_reg          <= DW'(root_n) * DW'(root_l);
            abs0_reg          <= (DW + 1)'(dot_abs);
            fl0_reg.degen     <= side.degen;
            fl0_reg.round_kind <= side.round_kind;
            fl0_reg.neg       <= side.dot[rhlc_pkg::DOT_W-1];
            fl0_reg.big       <= 1'b0;

            den1_reg           <= den0_reg;
            rem1_reg           <= abs0_reg;
            fl1_reg.degen      <= fl0_reg.degen;
            fl1_reg.round_kind <= fl0_reg.round_kind;
            fl1_reg.neg        <= fl0_reg.neg;
            // quotient reaches one: saturate
            fl1_reg.big        <= abs0_reg >= {1'b0, den0_reg};
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic          cur_vld;
        dflag_t        cur_fl;
        logic [DW-1:0] cur_den;
        logic [DW:0]   cur_rem;
        logic [QW-1:0] cur_q;
        logic [DW:0]   rem_next;
        logic [QW-1:0] q_next;

        if (s == 0)
        begin : g_in
            assign cur_vld = vld1_reg;
            assign cur_fl  = fl1_reg;
            assign cur_den = den1_reg;
            assign cur_rem = rem1_reg;
            assign cur_q   = '0;
        end
        else
        begin : g_mid
            assign cur_vld = vld_reg[s-1];
            assign cur_fl  = fl_reg[s-1];
            assign cur_den = den_reg[s-1];
            assign cur_rem = rem_reg[s-1];
            assign cur_q   = q_reg[s-1];
        end

        always_comb
        begin
            rem_next = cur_rem;
            q_next   = cur_q;
            for (int k = 0; k < rhlc_pkg::DIV_BPS; k++)
            begin
                rem_next = {rem_next[DW-1:0], 1'b0};
                if (rem_next >= {1'b0, cur_den})
                begin
                    rem_next = rem_next - {1'b0, cur_den};
                    q_next   = {q_next[QW-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_next[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= cur_vld;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                fl_reg[s]  <= cur_fl;
                den_reg[s] <= cur_den;
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
            end
        end
    end

    assign mag_next = fl_reg[NS-1].big ? rhlc_pkg::COS_ONE : CW'(q_reg[NS-1]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (fl_reg[NS-1].degen)
                cos_reg <= '0;
            else if (fl_reg[NS-1].neg)
                cos_reg <= -mag_next;
            else
                cos_reg <= mag_next;
            colour_reg <= fl_reg[NS-1].round_kind ? rhlc_pkg::COLOUR_ROUND
                                                  : rhlc_pkg::COLOUR_SPHERE;
            degen_reg  <= fl_reg[NS-1].degen;
        end
    end

    assign vld_out    = vld_out_reg;
    assign cosine     = cos_reg;
    assign colour     = colour_reg;
    assign degenerate = degen_reg;

endmodule

// ===== hdl/ray_hit_light_cosine.sv =====
// Lambert shading of one ray hit per cycle against a point light. Each request gives the hit
// point origin + dir * hit_distance, takes it (z cleared for cylinder and cone) as the normal,
// and returns the Q1.14 cosine to the light, the kind colour and a degenerate flag. The pipeline
// is 25 register stages deep: three for the hit point and light vector, two for block
// normalization, two for the dot products, eight for the two square roots (three bits a stage)
// and ten for the product of roots and the 14-bit quotient (two bits a stage) with the output
// register. A new request is taken every cycle; a held result stops the whole pipeline, and
// req_stall follows it in the same cycle. The user must write the light position via the cfg
// port while no request is in flight; the block does not enforce it. cfg_ready is always high.
`include "ray_hit_light_cosine_assert.svh"

module ray_hit_light_cosine #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic [rhlc_pkg::TYPE_W-1:0]            req_type,
    input  logic signed [rhlc_pkg::XW-1:0]         origin_x,
    input  logic signed [rhlc_pkg::XW-1:0]         origin_y,
    input  logic signed [rhlc_pkg::XW-1:0]         origin_z,
    input  logic signed [rhlc_pkg::XW-1:0]         dir_x,
    input  logic signed [rhlc_pkg::XW-1:0]         dir_y,
    input  logic signed [rhlc_pkg::XW-1:0]         dir_z,
    input  logic [rhlc_pkg::DIST_W-1:0]            hit_distance,

    output logic                                   res_valid,
    input  logic                                   res_stall,
    output logic signed [rhlc_pkg::COS_W-1:0]      cosine,
    output logic [rhlc_pkg::COLOUR_W-1:0]          colour,
    output logic                                   degenerate,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rhlc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rhlc_pkg::XW-1:0]                cfg_data
);

    logic                  adv;
    rhlc_pkg::coord_t      light_x_reg, light_y_reg, light_z_reg;
    rhlc_pkg::coord_t [2:0] origin, dir, light;

    logic                  pt_vld, pt_round;
    rhlc_pkg::coord_t [2:0] pt_n, pt_l;
    logic                  nm_vld, nm_degen, nm_round;
    rhlc_pkg::nvec_t [2:0] nm_nv, nm_lv;
    logic                  dt_vld;
    rhlc_pkg::side_t       dt_side;
    logic [rhlc_pkg::SQ_W-1:0] dt_nn, dt_ll;
    logic                  sq_vld;
    rhlc_pkg::side_t       sq_side;
    logic [rhlc_pkg::ROOT_W-1:0] sq_root_n, sq_root_l;

    assign adv       = !(res_valid && res_stall);
    assign req_stall = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rhlc_pkg::CFG_LIGHT_X: light_x_reg <= cfg_data;
                rhlc_pkg::CFG_LIGHT_Y: light_y_reg <= cfg_data;
                rhlc_pkg::CFG_LIGHT_Z: light_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign origin = {origin_z, origin_y, origin_x};
    assign dir    = {dir_z, dir_y, dir_x};
    assign light  = {light_z_reg, light_y_reg, light_x_reg};

    rhlc_point #(
        .FRAC_BITS (FRAC_BITS)
    ) u_point (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .vld        (req_valid),
        .round_kind (req_type != rhlc_pkg::KIND_SPHERE),
        .origin     (origin),
        .dir        (dir),
        .light      (light),
        .hit_dist   (hit_distance),
        .vld_out    (pt_vld),
        .round_out  (pt_round),
        .n          (pt_n),
        .l          (pt_l)
    );

    rhlc_norm u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .vld        (pt_vld),
        .round_kind (pt_round),
        .n          (pt_n),
        .l          (pt_l),
        .vld_out    (nm_vld),
        .degen      (nm_degen),
        .round_out  (nm_round),
        .nv         (nm_nv),
        .lv         (nm_lv)
    );

    rhlc_dot u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .vld        (nm_vld),
        .degen      (nm_degen),
        .round_kind (nm_round),
        .nv         (nm_nv),
        .lv         (nm_lv),
        .vld_out    (dt_vld),
        .side       (dt_side),
        .nn         (dt_nn),
        .ll         (dt_ll)
    );

    rhlc_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .vld        (dt_vld),
        .side       (dt_side),
        .rad_n      (dt_nn),
        .rad_l      (dt_ll),
        .vld_out    (sq_vld),
        .side_out   (sq_side),
        .root_n     (sq_root_n),
        .root_l     (sq_root_l)
    );

    rhlc_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .vld        (sq_vld),
        .side       (sq_side),
        .root_n     (sq_root_n),
        .root_l     (sq_root_l),
        .vld_out    (res_valid),
        .cosine     (cosine),
        .colour     (colour),
        .degenerate (degenerate)
    );

    `RHLC_ASSERT_HOLDS(a_degen_zero, clk, rst_n, res_valid && degenerate, cosine == '0)
    `RHLC_ASSERT_HOLDS(a_cos_range, clk, rst_n, res_valid, cosine <= rhlc_pkg::COS_ONE && cosine >= -rhlc_pkg::COS_ONE)
    `RHLC_ASSERT_HOLDS(a_colour_known, clk, rst_n, res_valid, colour == rhlc_pkg::COLOUR_SPHERE || colour == rhlc_pkg::COLOUR_ROUND)

endmodule
